### rtl/core/bcsu_pkg.sv
// B-spline charge spreading unit: shared types, codes and helpers.
// No dependencies.
`default_nettype none
package bcsu_pkg;

    localparam logic [2:0] CMD_LOAD_COEF = 3'd0;
    localparam logic [2:0] CMD_LOAD_MAT  = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_SPREAD    = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_SATURATED = 2'd2;

    // widest counters over the legal parameter range
    localparam int TAP_W_MAX  = 4;
    localparam int CELL_W_MAX = 21;

    typedef struct packed {
        logic        [2:0]  command;
        logic        [11:0] target_index;
        logic signed [31:0] load_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] particle_charge;
    } bcsu_in_t;

    typedef struct packed {
        logic signed [47:0] cell_value;
        logic        [1:0]  status;
    } bcsu_out_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_COEF,
        DP_LOAD_MAT,
        DP_CLEAR,
        DP_READ,
        DP_MAT_MUL,
        DP_MAT_ACC,
        DP_H_INIT,
        DP_H_MUL,
        DP_H_ADD,
        DP_XY_MUL,
        DP_XY_SAT,
        DP_W_MUL,
        DP_W_SAT,
        DP_T_MUL,
        DP_T_ACC,
        DP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [1:0]              row;
        logic [1:0]              col;
        logic [1:0]              axis;
        logic [TAP_W_MAX-1:0]    tap;
        logic [TAP_W_MAX-1:0]    hk;
        logic [TAP_W_MAX-1:0]    i;
        logic [TAP_W_MAX-1:0]    j;
        logic [TAP_W_MAX-1:0]    k;
        logic [CELL_W_MAX-1:0]   clr_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       out_free;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/bcsu_datapath.sv
// Datapath: request register, coefficient and matrix stores, shared 33x33
// multiplier, weight registers, charge grid memory and result register.
// Depends on bcsu_pkg.
`default_nettype none
module bcsu_datapath
    import bcsu_pkg::*;
#(
    parameter int SPLINE_ORDER = 4,
    parameter int GRID_BITS_X  = 4,
    parameter int GRID_BITS_Y  = 4,
    parameter int GRID_BITS_Z  = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire bcsu_in_t  s_data,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bcsu_out_t      m_data
);

    localparam int HALF       = SPLINE_ORDER / 2;
    localparam int TAPS       = 2 * HALF;
    localparam int COEF_DEPTH = ((SPLINE_ORDER + 1) / 2) * SPLINE_ORDER;
    localparam int CW         = $clog2(COEF_DEPTH);
    localparam int TW         = $clog2(TAPS);
    localparam int HW         = $clog2(SPLINE_ORDER);
    localparam int GB         = GRID_BITS_X + GRID_BITS_Y + GRID_BITS_Z;
    localparam int CELLS      = 1 << GB;

    bcsu_in_t           req_reg;
    logic signed [31:0] coef_reg [COEF_DEPTH];
    logic signed [31:0] mat_reg  [9];
    logic        [39:0] frac_reg [3];
    logic signed [31:0] wgt_reg  [3][TAPS];
    logic signed [31:0] acc_reg;
    logic signed [31:0] wxy_reg;
    logic signed [31:0] w_reg;
    logic signed [65:0] prod_reg;
    logic        [1:0]  status_reg;
    logic signed [47:0] grid_mem [CELLS];
    logic signed [47:0] rd_data_reg;
    logic               m_valid_reg;
    bcsu_out_t          m_data_reg;

    logic        [CW+11:0] coef_ext;
    logic        [GB+11:0] cell_ext;
    logic        [CW-1:0]  coef_waddr;
    logic        [GB-1:0]  cell_rd_addr;
    logic                  coef_ok;
    logic                  mat_ok;
    logic                  cell_ok;
    logic [GRID_BITS_X-1:0] m_x;
    logic [GRID_BITS_Y-1:0] m_y;
    logic [GRID_BITS_Z-1:0] m_z;
    logic        [27:0]    t_sel;
    logic        [28:0]    tt;
    logic        [TW-1:0]  tap;
    logic        [HW-1:0]  hk;
    logic        [TW-1:0]  ci;
    logic        [TW-1:0]  cj;
    logic        [TW-1:0]  ck;
    logic        [CW-1:0]  coef_raddr;
    logic signed [31:0]    coef_rd;
    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    logic signed [31:0]    pos_sel;
    logic [GRID_BITS_X+4:0] cx_full;
    logic [GRID_BITS_Y+4:0] cy_full;
    logic [GRID_BITS_Z+4:0] cz_full;
    logic        [GB-1:0]  cell_addr;
    logic signed [65:0]    horner_sum;
    logic signed [65:0]    cell_sum;
    logic signed [47:0]    cell_new;
    logic                  cell_sat;
    logic                  grid_we;
    logic        [GB-1:0]  grid_waddr;
    logic signed [47:0]    grid_wdata;
    logic                  grid_re;
    logic        [GB-1:0]  grid_raddr;

    assign coef_ext     = {{CW{1'b0}}, req_reg.target_index};
    assign cell_ext     = {{GB{1'b0}}, req_reg.target_index};
    assign coef_waddr   = coef_ext[CW-1:0];
    assign cell_rd_addr = cell_ext[GB-1:0];
    assign coef_ok      = {20'd0, req_reg.target_index} < 32'(COEF_DEPTH);
    assign mat_ok       = req_reg.target_index < 12'd9;
    assign cell_ok      = {20'd0, req_reg.target_index} < 32'(CELLS);

    assign m_x = frac_reg[0][39 -: GRID_BITS_X];
    assign m_y = frac_reg[1][39 -: GRID_BITS_Y];
    assign m_z = frac_reg[2][39 -: GRID_BITS_Z];

    assign tap = cmd.tap[TW-1:0];
    assign hk  = cmd.hk[HW-1:0];
    assign ci  = cmd.i[TW-1:0];
    assign cj  = cmd.j[TW-1:0];
    assign ck  = cmd.k[TW-1:0];

    always_comb begin
        case (cmd.axis)
            2'd0:    t_sel = frac_reg[0][39-GRID_BITS_X -: 28];
            2'd1:    t_sel = frac_reg[1][39-GRID_BITS_Y -: 28];
            default: t_sel = frac_reg[2][39-GRID_BITS_Z -: 28];
        endcase
    end

    // mirrored taps use row order-1-j at offset 1-t
    always_comb begin
        int row;
        row = (int'(tap) < HALF) ? int'(tap) : SPLINE_ORDER - 1 - int'(tap);
        tt  = (int'(tap) < HALF) ? {1'b0, t_sel} : (29'h1000_0000 - {1'b0, t_sel});
        if (cmd.op == DP_H_INIT) begin
            coef_raddr = CW'(row * SPLINE_ORDER + SPLINE_ORDER - 1);
        end else begin
            coef_raddr = CW'(row * SPLINE_ORDER + int'(hk));
        end
    end

    assign coef_rd = coef_reg[coef_raddr];

    always_comb begin
        case (cmd.col)
            2'd0:    pos_sel = req_reg.pos_x;
            2'd1:    pos_sel = req_reg.pos_y;
            default: pos_sel = req_reg.pos_z;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MAT_MUL: begin
                mul_a = 33'(mat_reg[4'(3 * int'(cmd.row) + int'(cmd.col))]);
                mul_b = 33'(pos_sel);
            end
            DP_H_MUL: begin
                mul_a = $signed({4'd0, tt});
                mul_b = 33'(acc_reg);
            end
            DP_XY_MUL: begin
                mul_a = 33'(wgt_reg[0][ci]);
                mul_b = 33'(wgt_reg[1][cj]);
            end
            DP_W_MUL: begin
                mul_a = 33'(wxy_reg);
                mul_b = 33'(wgt_reg[2][ck]);
            end
            DP_T_MUL: begin
                mul_a = 33'(w_reg);
                mul_b = 33'(req_reg.particle_charge);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cx_full = {5'd0, m_x} + (GRID_BITS_X+5)'(HALF) - (GRID_BITS_X+5)'(ci);
    assign cy_full = {5'd0, m_y} + (GRID_BITS_Y+5)'(HALF) - (GRID_BITS_Y+5)'(cj);
    assign cz_full = {5'd0, m_z} + (GRID_BITS_Z+5)'(HALF) - (GRID_BITS_Z+5)'(ck);
    assign cell_addr = {cx_full[GRID_BITS_X-1:0], cy_full[GRID_BITS_Y-1:0],
                        cz_full[GRID_BITS_Z-1:0]};

    assign horner_sum = 66'(coef_rd) + (prod_reg >>> 28);
    assign cell_sum   = 66'(rd_data_reg) + (prod_reg >>> 8);

    always_comb begin
        cell_sat = 1'b0;
        cell_new = cell_sum[47:0];
        if (cell_sum > 66'sd140737488355327) begin
            cell_new = 48'sh7FFF_FFFF_FFFF;
            cell_sat = 1'b1;
        end else if (cell_sum < -66'sd140737488355328) begin
            cell_new = 48'sh8000_0000_0000;
            cell_sat = 1'b1;
        end
    end

    assign grid_we    = (cmd.op == DP_CLEAR) || (cmd.op == DP_T_ACC);
    assign grid_waddr = (cmd.op == DP_CLEAR) ? cmd.clr_addr[GB-1:0] : cell_addr;
    assign grid_wdata = (cmd.op == DP_CLEAR) ? 48'sd0 : cell_new;
    assign grid_re    = (cmd.op == DP_READ) || (cmd.op == DP_T_MUL);
    assign grid_raddr = (cmd.op == DP_READ) ? cell_rd_addr : cell_addr;

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re) begin
            rd_data_reg <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < COEF_DEPTH; n++) begin
                coef_reg[n] <= '0;
            end
            for (int n = 0; n < 9; n++) begin
                mat_reg[n] <= '0;
            end
        end else begin
            if (cmd.op == DP_LOAD_COEF && coef_ok) begin
                coef_reg[coef_waddr] <= req_reg.load_value;
            end
            if (cmd.op == DP_LOAD_MAT && mat_ok) begin
                mat_reg[req_reg.target_index[3:0]] <= req_reg.load_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_CAPTURE) begin
            req_reg <= s_data;
        end
        if (cmd.op != DP_NOP) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == DP_MAT_ACC) begin
            frac_reg[cmd.row] <= ((cmd.col == 2'd0) ? 40'd0 : frac_reg[cmd.row])
                                 + prod_reg[39:0];
        end
        if (cmd.op == DP_H_INIT) begin
            acc_reg <= coef_rd;
        end
        if (cmd.op == DP_H_ADD) begin
            acc_reg                 <= sat32(horner_sum);
            wgt_reg[cmd.axis][tap]  <= sat32(horner_sum);
        end
        if (cmd.op == DP_XY_SAT) begin
            wxy_reg <= sat32(prod_reg >>> 28);
        end
        if (cmd.op == DP_W_SAT) begin
            w_reg <= sat32(prod_reg >>> 28);
        end
        if (cmd.op == DP_RESP) begin
            m_data_reg.status     <= status_reg;
            m_data_reg.cell_value <= (req_reg.command == CMD_READ && status_reg == STAT_DONE)
                                     ? rd_data_reg : 48'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= STAT_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                DP_CAPTURE:   status_reg <= STAT_DONE;
                DP_LOAD_COEF: if (!coef_ok) status_reg <= STAT_BAD_INDEX;
                DP_LOAD_MAT:  if (!mat_ok) status_reg <= STAT_BAD_INDEX;
                DP_READ:      if (!cell_ok) status_reg <= STAT_BAD_INDEX;
                DP_T_ACC:     if (cell_sat) status_reg <= STAT_SATURATED;
                default:      status_reg <= status_reg;
            endcase
            if (cmd.op == DP_RESP) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.command  = req_reg.command;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule
`default_nettype wire

### rtl/core/bcsu_ctrl.sv
// Controller: sequences the datapath through loads, grid clearing, matrix
// product, Horner weight evaluation and cell accumulation.
// Depends on bcsu_pkg.
`default_nettype none
module bcsu_ctrl
    import bcsu_pkg::*;
#(
    parameter int SPLINE_ORDER = 4,
    parameter int GRID_BITS_X  = 4,
    parameter int GRID_BITS_Y  = 4,
    parameter int GRID_BITS_Z  = 4
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam int HALF = SPLINE_ORDER / 2;
    localparam int TAPS = 2 * HALF;
    localparam int TW   = $clog2(TAPS);
    localparam int HW   = $clog2(SPLINE_ORDER);
    localparam int GB   = GRID_BITS_X + GRID_BITS_Y + GRID_BITS_Z;

    typedef enum logic [4:0] {
        S_CLR_RST, S_IDLE, S_EXEC, S_CLEAR, S_MAT_MUL, S_MAT_ACC,
        S_H_INIT, S_H_MUL, S_H_ADD, S_XY_MUL, S_XY_SAT, S_W_MUL,
        S_W_SAT, S_T_MUL, S_T_ACC, S_RESP
    } state_t;

    state_t        state_reg;
    logic [1:0]    row_reg;
    logic [1:0]    col_reg;
    logic [1:0]    axis_reg;
    logic [TW-1:0] tap_reg;
    logic [HW-1:0] hk_reg;
    logic [TW-1:0] i_reg;
    logic [TW-1:0] j_reg;
    logic [TW-1:0] k_reg;
    logic [GB-1:0] clr_reg;
    logic          last_tap;

    assign last_tap = 1'b1;
    assign s_ready  = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_RST;
            row_reg   <= '0;
            col_reg   <= '0;
            axis_reg  <= '0;
            tap_reg   <= '0;
            hk_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            clr_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_CLR_RST: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (stat.command)
                        CMD_CLEAR: begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        CMD_SPREAD: begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= S_MAT_MUL;
                        end
                        default: state_reg <= S_RESP;
                    endcase
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) state_reg <= S_RESP;
                end
                S_MAT_MUL: state_reg <= S_MAT_ACC;
                S_MAT_ACC: begin
                    state_reg <= S_MAT_MUL;
                    if (col_reg == 2'd2) begin
                        col_reg <= '0;
                        if (row_reg == 2'd2) begin
                            axis_reg  <= '0;
                            tap_reg   <= '0;
                            state_reg <= S_H_INIT;
                        end else begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end else begin
                        col_reg <= col_reg + 2'd1;
                    end
                end
                S_H_INIT: begin
                    hk_reg    <= HW'(SPLINE_ORDER - 2);
                    state_reg <= S_H_MUL;
                end
                S_H_MUL: state_reg <= S_H_ADD;
                S_H_ADD: begin
                    if (hk_reg == '0) begin
                        state_reg <= S_H_INIT;
                        if (tap_reg == TW'(TAPS - 1)) begin
                            tap_reg <= '0;
                            if (axis_reg == 2'd2) begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                state_reg <= S_XY_MUL;
                            end else begin
                                axis_reg <= axis_reg + 2'd1;
                            end
                        end else begin
                            tap_reg <= tap_reg + 1'b1;
                        end
                    end else begin
                        hk_reg    <= hk_reg - 1'b1;
                        state_reg <= S_H_MUL;
                    end
                end
                S_XY_MUL: state_reg <= S_XY_SAT;
                S_XY_SAT: begin
                    k_reg     <= '0;
                    state_reg <= S_W_MUL;
                end
                S_W_MUL: state_reg <= S_W_SAT;
                S_W_SAT: state_reg <= S_T_MUL;
                S_T_MUL: state_reg <= S_T_ACC;
                S_T_ACC: begin
                    if (k_reg == TW'(TAPS - 1)) begin
                        state_reg <= S_XY_MUL;
                        if (j_reg == TW'(TAPS - 1)) begin
                            j_reg <= '0;
                            if (i_reg == TW'(TAPS - 1) && last_tap) begin
                                state_reg <= S_RESP;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_W_MUL;
                    end
                end
                S_RESP: begin
                    if (stat.out_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.axis     = axis_reg;
        cmd.tap      = TAP_W_MAX'(tap_reg);
        cmd.hk       = TAP_W_MAX'(hk_reg);
        cmd.i        = TAP_W_MAX'(i_reg);
        cmd.j        = TAP_W_MAX'(j_reg);
        cmd.k        = TAP_W_MAX'(k_reg);
        cmd.clr_addr = CELL_W_MAX'(clr_reg);
        cmd.op       = DP_NOP;
        unique case (state_reg)
            S_CLR_RST, S_CLEAR: cmd.op = DP_CLEAR;
            S_IDLE:    cmd.op = s_valid ? DP_CAPTURE : DP_NOP;
            S_EXEC: begin
                case (stat.command)
                    CMD_LOAD_COEF: cmd.op = DP_LOAD_COEF;
                    CMD_LOAD_MAT:  cmd.op = DP_LOAD_MAT;
                    CMD_READ:      cmd.op = DP_READ;
                    default:       cmd.op = DP_NOP;
                endcase
            end
            S_MAT_MUL: cmd.op = DP_MAT_MUL;
            S_MAT_ACC: cmd.op = DP_MAT_ACC;
            S_H_INIT:  cmd.op = DP_H_INIT;
            S_H_MUL:   cmd.op = DP_H_MUL;
            S_H_ADD:   cmd.op = DP_H_ADD;
            S_XY_MUL:  cmd.op = DP_XY_MUL;
            S_XY_SAT:  cmd.op = DP_XY_SAT;
            S_W_MUL:   cmd.op = DP_W_MUL;
            S_W_SAT:   cmd.op = DP_W_SAT;
            S_T_MUL:   cmd.op = DP_T_MUL;
            S_T_ACC:   cmd.op = DP_T_ACC;
            S_RESP:    cmd.op = stat.out_free ? DP_RESP : DP_NOP;
            default:   cmd.op = DP_NOP;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/bspline_charge_spreading_unit.sv
// Top level of the B-spline charge spreading unit: controller plus datapath.
// Depends on bcsu_pkg, bcsu_ctrl and bcsu_datapath.
//
// One request is worked at a time; the result register lets the next request
// in while a result waits. After reset the grid is swept clear, all of its
// 2^(GRID_BITS_X+GRID_BITS_Y+GRID_BITS_Z) cells (4096 by default), before the
// first request is taken. Loads, reads and unknown commands pass through the
// capture, execute and response states; a clear also sweeps every grid cell.
// A spread's run time is set by the single shared 33x33 multiplier, through
// which every matrix, Horner and weight product passes, and by one grid
// read-modify-write per cell.
`default_nettype none
module bspline_charge_spreading_unit
    import bcsu_pkg::*;
#(
    parameter int SPLINE_ORDER = 4,
    parameter int GRID_BITS_X  = 4,
    parameter int GRID_BITS_Y  = 4,
    parameter int GRID_BITS_Z  = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire bcsu_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bcsu_out_t      m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bcsu_ctrl #(
        .SPLINE_ORDER (SPLINE_ORDER),
        .GRID_BITS_X  (GRID_BITS_X),
        .GRID_BITS_Y  (GRID_BITS_Y),
        .GRID_BITS_Z  (GRID_BITS_Z)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bcsu_datapath #(
        .SPLINE_ORDER (SPLINE_ORDER),
        .GRID_BITS_X  (GRID_BITS_X),
        .GRID_BITS_Y  (GRID_BITS_Y),
        .GRID_BITS_Z  (GRID_BITS_Z)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

### rtl/core/bcsu_checker.sv
// Port-level checks for the B-spline charge spreading unit, bound to the top.
// Depends on bcsu_pkg.
`default_nettype none
module bcsu_checker
    import bcsu_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire bcsu_out_t m_data
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in progress");

    a_value_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cell_value != 48'sd0 |-> m_data.status == STAT_DONE)
        else $error("cell value with error status");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bspline_charge_spreading_unit bcsu_checker u_bcsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
